/* rtl/core/csa_pkg.sv */
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and constants of the capability slot allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

    localparam int CAP_W = 11;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] REG_CAP_LIMIT = 2'd0;
    localparam logic [1:0] REG_ID_MULT   = 2'd1;
    localparam logic [1:0] REG_ID_INV    = 2'd2;
    localparam logic [1:0] REG_ID_BASE   = 2'd3;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_INVALID_ID  = 3'd1,
        STS_NULL_CAP    = 3'd2,
        STS_WRONG_TYPE  = 3'd3,
        STS_NO_RIGHTS   = 3'd4,
        STS_FULL        = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] cap_id;
        logic [63:0] object_handle;
        logic [3:0]  object_type;
        logic        any_type;
        logic [31:0] rights;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [63:0]      issued_cap_id;
        logic [63:0]      found_handle;
        logic [3:0]       found_type;
        logic [CAP_W-1:0] caps_in_use;
    } rsp_t;

    typedef struct packed {
        logic [63:0] handle;
        logic [3:0]  kind;
        logic [31:0] rights;
    } entry_t;

endpackage

/* rtl/core/csa_id_codec.sv */
// ----------------------------------------------------------------------------
// csa_id_codec
// Two-stage id decoder: unscramble by xor, multiply by the reciprocal, range check.
// ----------------------------------------------------------------------------
module csa_id_codec #(
    parameter int TABLE_COUNT      = 16,
    parameter int SLOTS_PER_TABLE  = 64,
    parameter int LOWER_INDEX_BITS = 8,
    parameter int TBL_W            = 4,
    parameter int SLOT_W           = 6
) (
    input  logic              clk,
    input  logic              load,
    input  logic              mul_en,
    input  logic [63:0]       cap_id,
    input  logic [63:0]       id_base,
    input  logic [32:0]       id_inverse,
    output logic              dec_ok,
    output logic [TBL_W-1:0]  dec_tbl,
    output logic [SLOT_W-1:0] dec_slot
);
    import csa_pkg::*;

    logic [31:0] r_lo_reg;
    logic        r_ok_reg;
    logic [32:0] inv_reg;
    logic [63:0] prod_reg;
    logic [31:0] hi_reg;
    logic        ok2_reg;
    logic [63:0] r;
    logic [31:0] sum_hi;
    logic [31:0] v32;
    logic [31:0] up32;
    logic [31:0] lo32;

    assign r = cap_id ^ id_base;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            r_lo_reg <= r[31:0];
            r_ok_reg <= (r[63:32] == 32'd0);
            inv_reg  <= id_inverse;
        end
        if (mul_en)
        begin
            prod_reg <= 64'(r_lo_reg) * 64'(inv_reg[31:0]);
            hi_reg   <= inv_reg[32] ? r_lo_reg : 32'd0;
            ok2_reg  <= r_ok_reg;
        end
    end

    // top bit of the reciprocal adds r shifted up by 32, wraps at 2^64
    assign sum_hi = prod_reg[63:32] + hi_reg;
    assign v32    = {16'd0, sum_hi[15:0]};
    assign up32   = v32 >> LOWER_INDEX_BITS;
    assign lo32   = v32 & ((32'd1 << LOWER_INDEX_BITS) - 32'd1);

    assign dec_ok   = ok2_reg && (sum_hi[31:16] == 16'd0)
                      && (up32 < 32'(TABLE_COUNT)) && (lo32 < 32'(SLOTS_PER_TABLE));
    assign dec_tbl  = up32[TBL_W-1:0];
    assign dec_slot = lo32[SLOT_W-1:0];

endmodule

/* rtl/core/csa_store.sv */
// ----------------------------------------------------------------------------
// csa_store
// Slot bitmap rows and slot payload memory, with registered reads.
// ----------------------------------------------------------------------------
module csa_store #(
    parameter int TABLE_COUNT     = 16,
    parameter int SLOTS_PER_TABLE = 64,
    parameter int TBL_W           = 4,
    parameter int ADDR_W          = 10
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [TBL_W-1:0]           rd_tbl,
    input  logic [ADDR_W-1:0]          rd_addr,
    input  logic                       row_we,
    input  logic [TBL_W-1:0]           wr_tbl,
    input  logic [SLOTS_PER_TABLE-1:0] wr_row,
    input  logic                       data_we,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  csa_pkg::entry_t            wr_entry,
    output logic [SLOTS_PER_TABLE-1:0] row_q,
    output csa_pkg::entry_t            entry_q
);
    import csa_pkg::*;

    logic [SLOTS_PER_TABLE-1:0] bitmap_mem [TABLE_COUNT];
    entry_t                     data_mem   [TABLE_COUNT*SLOTS_PER_TABLE];

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            bitmap_mem[wr_tbl] <= wr_row;
        end
        if (rd_en)
        begin
            row_q <= bitmap_mem[rd_tbl];
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            entry_q <= data_mem[rd_addr];
        end
    end

endmodule

/* rtl/core/capability_slot_allocator.sv */
// ----------------------------------------------------------------------------
// capability_slot_allocator
// Two-level capability slot store with scrambled capability ids.
// ----------------------------------------------------------------------------
// Usage: raise start with a request while busy is low; the request is taken at
// that edge and busy stays high until the answer is out. The answer appears on
// result with done high for exactly one cycle, once the request has passed the
// reciprocal multiply, decode and memory read, and update and write back steps.
// One request runs at a time, so a new request is taken only after the
// read-modify-write of the slot memories for the last one is done.
// Allocate takes the first table with room, else the first free table, then
// its first free slot. Delete and lookup decode the id and check table and
// slot state; lookup then checks type and rights.
// Registers sit on the APB port at byte addresses 0, 8, 16, 24 (limit,
// multiplier, inverse, base); write them only while busy is low.
// Reset clears all tables and the live count; no clearing pass is needed since
// a table's bitmap row counts as empty while the table is unclaimed.
// The receiver cannot stall: done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module capability_slot_allocator #(
    parameter int TABLE_COUNT      = 16,
    parameter int SLOTS_PER_TABLE  = 64,
    parameter int LOWER_INDEX_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  csa_pkg::req_t request,
    output logic          done,
    output csa_pkg::rsp_t result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import csa_pkg::*;

    localparam int TBL_W  = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int SLOT_W = (SLOTS_PER_TABLE > 1) ? $clog2(SLOTS_PER_TABLE) : 1;
    localparam int TOTAL  = TABLE_COUNT * SLOTS_PER_TABLE;
    localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int FILL_W = $clog2(SLOTS_PER_TABLE + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DEC, ST_RD} state_t;

    state_t                   state_reg;
    req_t                     req_reg;
    logic [CAP_W-1:0]         cap_limit_reg;
    logic [15:0]              id_mult_reg;
    logic [32:0]              id_inv_reg;
    logic [63:0]              id_base_reg;
    logic [TABLE_COUNT-1:0]   claimed_reg;
    logic [TABLE_COUNT-1:0]   room_reg;
    logic [FILL_W-1:0]        fill_reg [TABLE_COUNT];
    logic [CAP_W-1:0]         live_reg;
    logic [TBL_W-1:0]         tbl_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic                     pre_fail_reg;
    status_t                  pre_status_reg;
    logic                     done_reg;
    rsp_t                     result_reg;

    logic                     cfg_we;
    logic                     dec_ok;
    logic [TBL_W-1:0]         dec_tbl;
    logic [SLOT_W-1:0]        dec_slot;
    logic                     room_found;
    logic [TBL_W-1:0]         room_idx;
    logic                     free_found;
    logic [TBL_W-1:0]         free_idx;
    logic [TBL_W-1:0]         pick_tbl;
    logic [ADDR_W-1:0]        rd_addr;
    logic [SLOTS_PER_TABLE-1:0] row_q;
    entry_t                   entry_q;
    logic [SLOTS_PER_TABLE-1:0] row_cur;
    logic                     slot_found;
    logic [SLOT_W-1:0]        slot_free;
    logic [SLOT_W-1:0]        slot_sel;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     row_we;
    logic [SLOTS_PER_TABLE-1:0] row_next;
    logic                     data_we;
    entry_t                   wr_entry;
    logic [FILL_W-1:0]        fill_cur;
    logic [31:0]              slot_value;
    logic [31:0]              mult_prod;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[4:3])
            REG_CAP_LIMIT: prdata = 64'(cap_limit_reg);
            REG_ID_MULT:   prdata = 64'(id_mult_reg);
            REG_ID_INV:    prdata = 64'(id_inv_reg);
            REG_ID_BASE:   prdata = id_base_reg;
            default:       prdata = 64'd0;
        endcase
    end

    csa_id_codec #(
        .TABLE_COUNT      (TABLE_COUNT),
        .SLOTS_PER_TABLE  (SLOTS_PER_TABLE),
        .LOWER_INDEX_BITS (LOWER_INDEX_BITS),
        .TBL_W            (TBL_W),
        .SLOT_W           (SLOT_W)
    ) u_codec (
        .clk        (clk),
        .load       (start && !busy),
        .mul_en     (state_reg == ST_MUL),
        .cap_id     (request.cap_id),
        .id_base    (id_base_reg),
        .id_inverse (id_inv_reg),
        .dec_ok     (dec_ok),
        .dec_tbl    (dec_tbl),
        .dec_slot   (dec_slot)
    );

    // first table with room, else first unclaimed table
    always_comb
    begin
        room_found = 1'b0;
        room_idx   = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < TABLE_COUNT; i++)
        begin
            if (room_reg[i] && !room_found)
            begin
                room_found = 1'b1;
                room_idx   = TBL_W'(i);
            end
            if (!claimed_reg[i] && !free_found)
            begin
                free_found = 1'b1;
                free_idx   = TBL_W'(i);
            end
        end
    end

    assign pick_tbl = (req_reg.operation == OP_ALLOC)
                      ? (room_found ? room_idx : free_idx) : dec_tbl;
    assign rd_addr  = ADDR_W'(32'(pick_tbl) * 32'(SLOTS_PER_TABLE) + 32'(dec_slot));

    csa_store #(
        .TABLE_COUNT     (TABLE_COUNT),
        .SLOTS_PER_TABLE (SLOTS_PER_TABLE),
        .TBL_W           (TBL_W),
        .ADDR_W          (ADDR_W)
    ) u_store (
        .clk      (clk),
        .rd_en    (state_reg == ST_DEC),
        .rd_tbl   (pick_tbl),
        .rd_addr  (rd_addr),
        .row_we   (row_we),
        .wr_tbl   (tbl_reg),
        .wr_row   (row_next),
        .data_we  (data_we),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .row_q    (row_q),
        .entry_q  (entry_q)
    );

    // an unclaimed table's row is stale, it reads as empty
    assign row_cur  = claimed_reg[tbl_reg] ? row_q : '0;
    assign fill_cur = claimed_reg[tbl_reg] ? fill_reg[tbl_reg] : '0;

    always_comb
    begin
        slot_found = 1'b0;
        slot_free  = '0;
        for (int i = 0; i < SLOTS_PER_TABLE; i++)
        begin
            if (!row_cur[i] && !slot_found)
            begin
                slot_found = 1'b1;
                slot_free  = SLOT_W'(i);
            end
        end
    end

    assign slot_sel   = (req_reg.operation == OP_ALLOC) ? slot_free : slot_reg;
    assign wr_addr    = ADDR_W'(32'(tbl_reg) * 32'(SLOTS_PER_TABLE) + 32'(slot_sel));
    assign slot_value = 32'((32'(tbl_reg) << LOWER_INDEX_BITS) | 32'(slot_free)) & 32'hFFFF;
    assign mult_prod  = slot_value[15:0] * id_mult_reg;

    assign wr_entry.handle = req_reg.object_handle;
    assign wr_entry.kind   = req_reg.object_type;
    assign wr_entry.rights = req_reg.rights;

    always_comb
    begin
        row_we   = 1'b0;
        data_we  = 1'b0;
        row_next = row_cur;
        if (state_reg == ST_RD && !pre_fail_reg)
        begin
            case (req_reg.operation)
                OP_ALLOC:
                begin
                    if (slot_found)
                    begin
                        row_we             = 1'b1;
                        data_we            = 1'b1;
                        row_next[slot_free] = 1'b1;
                    end
                end
                OP_DELETE:
                begin
                    if (row_cur[slot_reg])
                    begin
                        row_we             = 1'b1;
                        row_next[slot_reg] = 1'b0;
                    end
                end
                default:
                begin
                    row_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_limit_reg  <= '0;
            id_mult_reg    <= 16'd1;
            id_inv_reg     <= 33'h1_0000_0001;
            id_base_reg    <= '0;
            claimed_reg    <= '0;
            room_reg       <= '0;
            live_reg       <= '0;
            done_reg       <= 1'b0;
            pre_fail_reg   <= 1'b0;
            pre_status_reg <= STS_OK;
            for (int i = 0; i < TABLE_COUNT; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                case (paddr[4:3])
                    REG_CAP_LIMIT: cap_limit_reg <= pwdata[CAP_W-1:0];
                    REG_ID_MULT:   id_mult_reg   <= pwdata[15:0];
                    REG_ID_INV:    id_inv_reg    <= pwdata[32:0];
                    REG_ID_BASE:   id_base_reg   <= pwdata;
                    default:       id_base_reg   <= id_base_reg;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= request;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DEC;
                end
                ST_DEC:
                begin
                    tbl_reg  <= pick_tbl;
                    slot_reg <= dec_slot;
                    case (req_reg.operation)
                        OP_ALLOC:
                        begin
                            pre_fail_reg   <= (live_reg >= cap_limit_reg)
                                              || (!room_found && !free_found);
                            pre_status_reg <= STS_FULL;
                        end
                        OP_DELETE, OP_LOOKUP:
                        begin
                            pre_fail_reg   <= !dec_ok;
                            pre_status_reg <= STS_INVALID_ID;
                        end
                        default:
                        begin
                            pre_fail_reg   <= 1'b1;
                            pre_status_reg <= STS_INVALID_ID;
                        end
                    endcase
                    state_reg <= ST_RD;
                end
                ST_RD:
                begin
                    done_reg                 <= 1'b1;
                    state_reg                <= ST_IDLE;
                    result_reg.status        <= STS_OK;
                    result_reg.issued_cap_id <= '0;
                    result_reg.found_handle  <= '0;
                    result_reg.found_type    <= '0;
                    result_reg.caps_in_use   <= live_reg;
                    if (pre_fail_reg)
                    begin
                        result_reg.status <= pre_status_reg;
                    end
                    else
                    begin
                        case (req_reg.operation)
                            OP_ALLOC:
                            begin
                                if (!slot_found)
                                begin
                                    result_reg.status <= STS_FULL;
                                end
                                else
                                begin
                                    claimed_reg[tbl_reg]     <= 1'b1;
                                    fill_reg[tbl_reg]        <= fill_cur + 1'b1;
                                    room_reg[tbl_reg]        <=
                                        ((fill_cur + 1'b1) < FILL_W'(SLOTS_PER_TABLE));
                                    live_reg                 <= live_reg + 1'b1;
                                    result_reg.caps_in_use   <= live_reg + 1'b1;
                                    result_reg.issued_cap_id <= 64'(mult_prod) ^ id_base_reg;
                                end
                            end
                            OP_DELETE:
                            begin
                                if (!claimed_reg[tbl_reg] || !row_cur[slot_reg])
                                begin
                                    result_reg.status <= STS_NULL_CAP;
                                end
                                else
                                begin
                                    if (fill_cur >= FILL_W'(SLOTS_PER_TABLE))
                                    begin
                                        room_reg[tbl_reg] <= 1'b1;
                                    end
                                    if (fill_cur > '0)
                                    begin
                                        fill_reg[tbl_reg] <= fill_cur - 1'b1;
                                    end
                                    if (fill_cur <= FILL_W'(1))
                                    begin
                                        claimed_reg[tbl_reg] <= 1'b0;
                                        room_reg[tbl_reg]    <= 1'b0;
                                    end
                                    if (live_reg > '0)
                                    begin
                                        live_reg               <= live_reg - 1'b1;
                                        result_reg.caps_in_use <= live_reg - 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                                if (!claimed_reg[tbl_reg] || !row_cur[slot_reg])
                                begin
                                    result_reg.status <= STS_NULL_CAP;
                                end
                                else if (!req_reg.any_type
                                         && entry_q.kind != req_reg.object_type)
                                begin
                                    result_reg.status <= STS_WRONG_TYPE;
                                end
                                else if ((entry_q.rights & req_reg.rights) != req_reg.rights)
                                begin
                                    result_reg.status <= STS_NO_RIGHTS;
                                end
                                else
                                begin
                                    result_reg.found_handle <= entry_q.handle;
                                    result_reg.found_type   <= entry_q.kind;
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_done_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_RD))
        else $error("result strobe without an update cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while result is presented");

    a_room_claimed: assert property (@(posedge clk) disable iff (!rst_n)
        (room_reg & ~claimed_reg) == '0)
        else $error("table has room but is not claimed");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CAP_W'(TOTAL))
        else $error("live count beyond slot capacity");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the capability slot allocator: directed and random
// allocate, delete and lookup requests against a behavioral slot store.
// ----------------------------------------------------------------------------
module tb;
    import csa_pkg::*;

    localparam int NTAB  = 16;
    localparam int NSLOT = 64;

    // operation code that the block does not define
    localparam logic [1:0] OP_UNUSED = 2'd3;

    class cap_scoreboard;
        logic [10:0] limit;
        logic [15:0] mult;
        logic [32:0] inv;
        logic [63:0] base;
        bit          claimed [NTAB];
        bit          room [NTAB];
        int          fill [NTAB];
        bit          used [NTAB][NSLOT];
        logic [63:0] hnd [NTAB*NSLOT];
        logic [3:0]  typ [NTAB*NSLOT];
        logic [31:0] rts [NTAB*NSLOT];
        int          live;
        rsp_t        pending [$];
        logic [63:0] live_ids [$];
        int          errors;
        int          checked;

        function new();
            limit = 0; mult = 1; inv = 33'h1_0000_0001; base = 0;
            live = 0; errors = 0; checked = 0;
            foreach (claimed[i])
            begin
                claimed[i] = 0; room[i] = 0; fill[i] = 0;
                foreach (used[i][j]) used[i][j] = 0;
            end
        endfunction

        function bit decode(logic [63:0] id, output int t, output int s);
            logic [63:0] r;
            logic [63:0] v;
            r = id ^ base;
            v = (r * {31'd0, inv}) >> 32;
            if (r[63:32] != 0 || v[63:16] != 0) return 0;
            t = int'(v[15:8]);
            s = int'(v[7:0]);
            return t < NTAB && s < NSLOT;
        endfunction

        function void note_request(req_t q);
            rsp_t o;
            int   t, s, idx;
            o = '0;
            t = -1; s = -1;
            case (q.operation)
                OP_ALLOC:
                begin
                    o.status = STS_FULL;
                    if (live < limit)
                    begin
                        for (int i = NTAB - 1; i >= 0; i--) if (room[i]) t = i;
                        if (t < 0)
                            for (int i = NTAB - 1; i >= 0; i--) if (!claimed[i]) t = i;
                        if (t >= 0)
                            for (int i = NSLOT - 1; i >= 0; i--) if (!used[t][i]) s = i;
                        if (s >= 0)
                        begin
                            if (!claimed[t])
                            begin
                                claimed[t] = 1; room[t] = 1; fill[t] = 0;
                            end
                            fill[t]++; live++;
                            if (fill[t] >= NSLOT) room[t] = 0;
                            used[t][s] = 1;
                            idx = t * NSLOT + s;
                            hnd[idx] = q.object_handle;
                            typ[idx] = q.object_type;
                            rts[idx] = q.rights;
                            o.status = STS_OK;
                            o.issued_cap_id = ({48'd0, t[7:0], s[7:0]} * {48'd0, mult}) ^ base;
                            live_ids.push_back(o.issued_cap_id);
                        end
                    end
                end
                OP_DELETE, OP_LOOKUP:
                begin
                    if (!decode(q.cap_id, t, s)) o.status = STS_INVALID_ID;
                    else if (!claimed[t] || !used[t][s]) o.status = STS_NULL_CAP;
                    else if (q.operation == OP_DELETE)
                    begin
                        used[t][s] = 0;
                        if (fill[t] >= NSLOT) room[t] = 1;
                        if (fill[t] > 0) fill[t]--;
                        if (live > 0) live--;
                        if (fill[t] == 0)
                        begin
                            claimed[t] = 0; room[t] = 0;
                        end
                        o.status = STS_OK;
                    end
                    else
                    begin
                        idx = t * NSLOT + s;
                        if (!q.any_type && typ[idx] != q.object_type) o.status = STS_WRONG_TYPE;
                        else if ((rts[idx] & q.rights) != q.rights) o.status = STS_NO_RIGHTS;
                        else
                        begin
                            o.status = STS_OK;
                            o.found_handle = hnd[idx];
                            o.found_type = typ[idx];
                        end
                    end
                end
                default: o.status = STS_INVALID_ID;
            endcase
            o.caps_in_use = live[10:0];
            pending.push_back(o);
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            checked++;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing pending", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (got.status != e.status) report_mismatch("status", got.status, e.status);
            if (got.issued_cap_id != e.issued_cap_id)
                report_mismatch("issued_cap_id", got.issued_cap_id, e.issued_cap_id);
            if (got.found_handle != e.found_handle)
                report_mismatch("found_handle", got.found_handle, e.found_handle);
            if (got.found_type != e.found_type)
                report_mismatch("found_type", got.found_type, e.found_type);
            if (got.caps_in_use != e.caps_in_use)
                report_mismatch("caps_in_use", got.caps_in_use, e.caps_in_use);
        endfunction

        function void report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= 30)
                $display("mismatch %s: got %h want %h (result %0d)", what, got, want, checked);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        done;
    rsp_t        result;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    cap_scoreboard sb;
    longint        cycles;
    int            n_sent;

    capability_slot_allocator u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        clk = 1'b0; #4;
        clk = 1'b1; #4;
    end

    initial
    begin
        rst_n = 1'b0; start = 1'b0; request = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        sb = new();
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("timeout");
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done) sb.check_result(result);

    task automatic gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send(req_t q);
        request <= q;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(q);
        n_sent++;
        start <= 1'b0;
        // the block stays busy here anyway
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_CAP_LIMIT: sb.limit = val[10:0];
            REG_ID_MULT:   sb.mult = val[15:0];
            REG_ID_INV:    sb.inv = val[32:0];
            default:       sb.base = val;
        endcase
        @(posedge clk);
    endtask

    // program a multiplier, its matching reciprocal and the id base
    task automatic set_scramble(logic [15:0] m, logic [63:0] b);
        logic [63:0] q;
        q = (64'h1_0000_0000 / m) + 1;
        write_reg(REG_ID_MULT, m);
        write_reg(REG_ID_INV, q);
        write_reg(REG_ID_BASE, b);
    endtask

    function automatic req_t rand_req(logic [1:0] op);
        req_t q;
        q.operation = op;
        q.cap_id = {$urandom, $urandom};
        q.object_handle = {$urandom, $urandom};
        q.object_type = 4'($urandom);
        q.any_type = 1'($urandom);
        q.rights = $urandom;
        return q;
    endfunction

    // mostly well-formed: alloc, delete or lookup of live ids, with some noise
    task automatic random_phase(int count, int alloc_pct);
        req_t q;
        int   k, r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct) q = rand_req(OP_ALLOC);
            else if (r < 97 || sb.live_ids.size() == 0)
            begin
                q = rand_req(r[0] ? OP_DELETE : OP_LOOKUP);
                if (sb.live_ids.size() != 0 && $urandom_range(0, 9) != 0)
                begin
                    k = $urandom_range(0, sb.live_ids.size() - 1);
                    q.cap_id = sb.live_ids[k];
                    if (q.operation == OP_DELETE && $urandom_range(0, 3) != 0)
                        sb.live_ids.delete(k);
                    if ($urandom_range(0, 2) == 0) q.rights = q.rights & $urandom;
                    if ($urandom_range(0, 3) == 0) q.rights = 0;
                end
                else if ($urandom_range(0, 1)) q.cap_id = q.cap_id & 64'hFFFF;
            end
            else q = rand_req(OP_UNUSED);
            send(q);
            gap();
        end
    endtask

    initial
    begin
        req_t q;
        n_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // limit zero: allocate is full; reserved op and bad ids
        send(rand_req(OP_ALLOC));
        send(rand_req(OP_UNUSED));
        q = rand_req(OP_DELETE); q.cap_id = '1; send(q);
        q = rand_req(OP_LOOKUP); q.cap_id = 0; send(q);
        drain();

        write_reg(REG_CAP_LIMIT, 11'd1024);
        q = rand_req(OP_ALLOC); q.object_handle = '1; q.object_type = 4'hF;
        q.rights = '1; send(q);
        q = rand_req(OP_ALLOC); q.object_handle = 0; q.object_type = 0;
        q.rights = 0; send(q);
        // lookup checks: ok, wrong type, any type, missing rights
        q = rand_req(OP_LOOKUP); q.cap_id = 0; q.object_type = 4'hF; q.any_type = 0;
        q.rights = '1; send(q);
        q.object_type = 4'h3; send(q);
        q.any_type = 1; send(q);
        q = rand_req(OP_LOOKUP); q.cap_id = 1; q.any_type = 1; q.rights = 32'h1; send(q);
        q.cap_id = 64'd63; send(q);
        q.cap_id = 64'd64; send(q);
        q.cap_id = 64'h1000; send(q);
        q.cap_id = 64'h1_0000_0000; send(q);
        q = rand_req(OP_DELETE); q.cap_id = 0; send(q);
        send(q);
        q.cap_id = 1; send(q);
        drain();

        // fill every table to reach the no-table case, then drain some
        sb.live_ids.delete();
        repeat (1030)
        begin
            send(rand_req(OP_ALLOC));
            if ($urandom_range(0, 7) == 0) gap();
        end
        drain();
        random_phase(120, 10);
        drain();

        set_scramble(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        random_phase(130, 50);
        drain();

        write_reg(REG_CAP_LIMIT, 11'd40);
        set_scramble(16'h0001, 64'h0000_0000_1234_5678);
        random_phase(120, 55);
        drain();

        write_reg(REG_CAP_LIMIT, 11'd300);
        set_scramble(16'($urandom_range(1, 65535)), {$urandom, $urandom});
        random_phase(130, 55);
        drain();

        // the live id list is cleared as base and multiplier change, so old ids are not reused
        write_reg(REG_CAP_LIMIT, 11'd700);
        set_scramble(16'($urandom_range(2, 300)), {32'd0, $urandom});
        sb.live_ids.delete();
        random_phase(100, 50);
        drain();

        write_reg(REG_ID_INV, 33'h1_FFFF_FFFF);
        random_phase(30, 30);
        drain();
        write_reg(REG_ID_INV, 33'd0);
        random_phase(20, 30);
        drain();

        $display("ran %0d requests over limits 0..1024 and several id scramblings", n_sent);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

/* files.f */
rtl/core/csa_pkg.sv
rtl/core/csa_id_codec.sv
rtl/core/csa_store.sv
rtl/core/capability_slot_allocator.sv
tb/tb.sv
